// File: sv/cfc_pkg.sv
`default_nettype none

package cfc_pkg;

	// Item function codes
	localparam logic [1:0] FN_TAP    = 2'd0;
	localparam logic [1:0] FN_SAMPLE = 2'd1;
	localparam logic [1:0] FN_PAD    = 2'd2;
	localparam logic [1:0] FN_CLEAR  = 2'd3;

	// Field widths
	localparam int FUNC_W   = 2;
	localparam int TIDX_W   = 6;
	localparam int TAP_W    = 24;
	localparam int SMP_W    = 16;
	localparam int PROD_W   = TAP_W + SMP_W;
	localparam int RES_W    = 32;
	localparam int FRAC_BITS = 15;
	// Smallest sum width that still leaves a guard bit above the 32-bit result.
	localparam int MIN_SUM_W = RES_W + FRAC_BITS + 1;

	// Configuration space
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int TCNT_W     = 7;
	localparam logic [CFG_ADDR_W-3:0] REG_TAP_COUNT   = '0;
	localparam logic [TCNT_W-1:0]     TAP_COUNT_RESET = 7'd64;

	// Per-cycle control shared by every cell of the chain
	typedef struct packed {
		logic win_shift;
		logic win_clear;
		logic top_load;
		logic top_shift;
	} cfc_ctrl_t;

endpackage

`default_nettype wire

// File: sv/cfc_stream_if.sv
`default_nettype none

interface cfc_item_if;
	logic                               valid;
	logic                               ready;
	logic [cfc_pkg::FUNC_W-1:0]         func;
	logic [cfc_pkg::TIDX_W-1:0]         tap_index;
	logic signed [cfc_pkg::TAP_W-1:0]   tap_value;
	logic signed [cfc_pkg::SMP_W-1:0]   sample;

	modport source (output valid, func, tap_index, tap_value, sample, input ready);
	modport sink (input valid, func, tap_index, tap_value, sample, output ready);
endinterface

interface cfc_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [cfc_pkg::RES_W-1:0]   filtered;
	logic                               saturated;

	modport source (output valid, filtered, saturated, input ready);
	modport sink (input valid, filtered, saturated, output ready);
endinterface

`default_nettype wire

// File: sv/cfc_cell.sv
`default_nettype none

// One tap position: delay-line stage, stored coefficient, operand stage,
// registered product and one link of the partial-sum chain.
module cfc_cell #(
	parameter int SUM_W = 48
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire cfc_pkg::cfc_ctrl_t                ctrl,
	input  wire logic                              tap_we,
	input  wire logic signed [cfc_pkg::TAP_W-1:0]  tap_wdata,
	input  wire logic signed [cfc_pkg::SMP_W-1:0]  win_in,
	output logic signed [cfc_pkg::SMP_W-1:0]       win_out,
	output logic signed [cfc_pkg::TAP_W-1:0]       tap_out,
	input  wire logic signed [cfc_pkg::TAP_W-1:0]  tap_load,
	input  wire logic signed [cfc_pkg::TAP_W-1:0]  top_in,
	output logic signed [cfc_pkg::TAP_W-1:0]       top_out,
	input  wire logic signed [SUM_W-1:0]           sum_in,
	output logic signed [SUM_W-1:0]                sum_out
);

	logic signed [cfc_pkg::SMP_W-1:0]  win_q;
	logic signed [cfc_pkg::TAP_W-1:0]  tap_q;
	logic signed [cfc_pkg::TAP_W-1:0]  top_q;
	logic signed [cfc_pkg::PROD_W-1:0] prod_s1;
	logic signed [SUM_W-1:0]           sum_q;
	logic signed [cfc_pkg::PROD_W-1:0] prod_d;

	assign prod_d = cfc_pkg::PROD_W'(top_q) * cfc_pkg::PROD_W'(win_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			tap_q <= '0;
		end else begin
			if (ctrl.win_clear) begin
				win_q <= '0;
			end else if (ctrl.win_shift) begin
				win_q <= win_in;
			end
			if (tap_we) begin
				tap_q <= tap_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.top_load) begin
			top_q <= tap_load;
		end else if (ctrl.top_shift) begin
			top_q <= top_in;
		end
		prod_s1 <= prod_d;
		sum_q   <= sum_in + SUM_W'(prod_s1);
	end

	assign win_out = win_q;
	assign tap_out = tap_q;
	assign top_out = top_q;
	assign sum_out = sum_q;

endmodule

`default_nettype wire

// File: sv/cfc_regs.sv
`default_nettype none

// APB register block: holds the tap count and returns it on reads.
module cfc_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [cfc_pkg::CFG_ADDR_W-1:0]      paddr,
	input  wire logic [cfc_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [cfc_pkg::CFG_DATA_W-1:0]           prdata,
	output logic                                     pready,
	output logic [cfc_pkg::TCNT_W-1:0]               tap_count
);

	logic [cfc_pkg::CFG_ADDR_W-3:0] reg_sel;
	logic [cfc_pkg::TCNT_W-1:0]     tap_count_q;
	logic                           wr_en;

	assign reg_sel = paddr[cfc_pkg::CFG_ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= cfc_pkg::TAP_COUNT_RESET;
		end else if (wr_en && (reg_sel == cfc_pkg::REG_TAP_COUNT)) begin
			tap_count_q <= pwdata[cfc_pkg::TCNT_W-1:0];
		end
	end

	always_comb begin
		case (reg_sel)
			cfc_pkg::REG_TAP_COUNT: prdata = cfc_pkg::CFG_DATA_W'(tap_count_q);
			default:                prdata = '0;
		endcase
	end

	assign tap_count = tap_count_q;

endmodule

`default_nettype wire

// File: sv/centered_fir_convolution.sv
// Centered FIR filter (correlation form, kernel not flipped). Each item on the
// item channel either writes one Q9.15 coefficient (tap write), shifts a Q1.15
// sample or a zero into the delay line (sample, pad), or empties the delay line
// (clear). A shift yields one result beat, sum of tap[j]*x[n-(K-1-j)] over the
// first K taps, shifted right by 15 with floor rounding and saturated to 32 bits,
// except for the first K-1-K/2 shifts after reset or clear, which only warm the
// filter up. K is the tap_count register (APB byte address 0) clamped to
// [1, TAPS]. Tap writes, clears and warm-up shifts leave the sequencer idle. A
// shift that produces a result occupies the filter: the coefficients are loaded
// reversed into an operand chain and moved TAPS-K places so that each cell pairs
// its window sample with the right coefficient, then the partial sum ripples
// through all TAPS cells of the chain, one cell a cycle. The result sits in an
// output register, so the next item is taken while it still waits to be
// collected. No clearing pass is needed after reset.
`default_nettype none

module centered_fir_convolution #(
	parameter int TAPS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	cfc_item_if.sink                             item,
	cfc_result_if.source                         result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [cfc_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [cfc_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [cfc_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                 pready
);

	// Counter wide enough to hold TAPS itself.
	localparam int CNT_W = $clog2(TAPS + 1);
	// The exact sum of TAPS products of 40 bits, kept at least wide enough
	// that the shifted value always has a bit above the 32-bit result.
	localparam int ACC_W = cfc_pkg::PROD_W + $clog2(TAPS);
	localparam int SUM_W = (ACC_W > cfc_pkg::MIN_SUM_W) ? ACC_W : cfc_pkg::MIN_SUM_W;
	localparam int QW    = SUM_W - cfc_pkg::FRAC_BITS;
	localparam logic [CNT_W-1:0] TAPS_C = CNT_W'(TAPS);
	localparam logic [cfc_pkg::TCNT_W-1:0] TAPS_K = cfc_pkg::TCNT_W'((TAPS > 127) ? 127 : TAPS);

	// Sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_SUM   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic signed [cfc_pkg::RES_W-1:0] RES_MAX = {1'b0, {(cfc_pkg::RES_W-1){1'b1}}};
	localparam logic signed [cfc_pkg::RES_W-1:0] RES_MIN = {1'b1, {(cfc_pkg::RES_W-1){1'b0}}};

	logic [cfc_pkg::TCNT_W-1:0] tap_count;
	logic [cfc_pkg::TCNT_W-1:0] k_eff;
	logic [cfc_pkg::TCNT_W-1:0] need;
	logic [CNT_W-1:0]           shift_amt;

	logic [1:0]                 state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [cfc_pkg::TCNT_W-1:0] warm_q;

	logic                       acc_item;
	logic                       acc_tap;
	logic                       acc_shift;
	logic                       acc_clear;
	logic                       do_result;
	logic signed [cfc_pkg::SMP_W-1:0] push_val;

	cfc_pkg::cfc_ctrl_t         ctrl;
	logic [TAPS-1:0]            tap_we;

	logic signed [cfc_pkg::SMP_W-1:0] win [TAPS];
	logic signed [cfc_pkg::TAP_W-1:0] tap [TAPS];
	logic signed [cfc_pkg::TAP_W-1:0] top [TAPS];
	logic signed [SUM_W-1:0]          psum [TAPS];

	logic signed [QW-1:0]             q;
	logic                             ovf;
	logic signed [cfc_pkg::RES_W-1:0] filt_d;
	logic                             load_res;

	logic                             res_valid_q;
	logic signed [cfc_pkg::RES_W-1:0] filt_q;
	logic                             sat_q;

	cfc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tap_count (tap_count)
	);

	// Effective kernel length, warm-up threshold and how far the reversed
	// coefficients must travel so that tap[K-1-m] lines up with window[m].
	always_comb begin
		if (tap_count == '0) begin
			k_eff = cfc_pkg::TCNT_W'(1);
		end else if (tap_count > TAPS_K) begin
			k_eff = TAPS_K;
		end else begin
			k_eff = tap_count;
		end
	end

	assign need      = k_eff - cfc_pkg::TCNT_W'(1) - (k_eff >> 1);
	assign shift_amt = TAPS_C - CNT_W'(k_eff);

	// Input side: an item is taken only while the sequencer is idle.
	assign item.ready = (state_q == ST_IDLE);
	assign acc_item   = item.valid && item.ready;
	assign acc_tap    = acc_item && (item.func == cfc_pkg::FN_TAP);
	assign acc_clear  = acc_item && (item.func == cfc_pkg::FN_CLEAR);
	assign acc_shift  = acc_item && ((item.func == cfc_pkg::FN_SAMPLE) ||
		(item.func == cfc_pkg::FN_PAD));
	assign do_result  = acc_shift && (warm_q >= need);
	assign push_val   = (item.func == cfc_pkg::FN_SAMPLE) ? item.sample : '0;

	// The operands are loaded at the shift itself, then the reversed
	// coefficients step down the chain until they sit against the right samples.
	assign ctrl.win_shift = acc_shift;
	assign ctrl.win_clear = acc_clear;
	assign ctrl.top_load  = acc_shift;
	assign ctrl.top_shift = (state_q == ST_SHIFT) && (cnt_q != shift_amt);

	// The row of cells. Cell c holds window[c] and tap[c]; its operand stage is
	// loaded from tap[TAPS-1-c] and later takes the value of its upper neighbour.
	for (genvar c = 0; c < TAPS; c++) begin : g_cell
		logic signed [cfc_pkg::SMP_W-1:0] win_in;
		logic signed [cfc_pkg::TAP_W-1:0] top_in;
		logic signed [SUM_W-1:0]          sum_in;

		assign tap_we[c] = acc_tap && (32'(item.tap_index) == c);

		if (c == 0) begin : g_first
			assign win_in = push_val;
			assign sum_in = '0;
		end else begin : g_rest
			assign win_in = win[c-1];
			assign sum_in = psum[c-1];
		end

		if (c == TAPS - 1) begin : g_last
			assign top_in = '0;
		end else begin : g_inner
			assign top_in = top[c+1];
		end

		cfc_cell #(
			.SUM_W (SUM_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.tap_we    (tap_we[c]),
			.tap_wdata (item.tap_value),
			.win_in    (win_in),
			.win_out   (win[c]),
			.tap_out   (tap[c]),
			.tap_load  (tap[TAPS-1-c]),
			.top_in    (top_in),
			.top_out   (top[c]),
			.sum_in    (sum_in),
			.sum_out   (psum[c])
		);
	end

	// Sequencer. In the sum phase the operands stand still while the product stage
	// and the partial-sum chain settle at the far end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			warm_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_clear) begin
						warm_q <= '0;
					end else if (acc_shift) begin
						if (warm_q < need) begin
							warm_q <= warm_q + cfc_pkg::TCNT_W'(1);
						end else begin
							warm_q  <= need;
							state_q <= ST_SHIFT;
							cnt_q   <= '0;
						end
					end
				end
				ST_SHIFT: begin
					if (cnt_q == shift_amt) begin
						state_q <= ST_SUM;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SUM: begin
					if (cnt_q == TAPS_C) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scale by 2^-15 with floor rounding, then clamp to 32 bits.
	assign q      = psum[TAPS-1][SUM_W-1:cfc_pkg::FRAC_BITS];
	assign ovf    = !((&q[QW-1:cfc_pkg::RES_W-1]) || !(|q[QW-1:cfc_pkg::RES_W-1]));
	assign filt_d = ovf ? (q[QW-1] ? RES_MIN : RES_MAX) : q[cfc_pkg::RES_W-1:0];

	// Output register: refilled from the chain once the previous beat has gone.
	assign load_res = (state_q == ST_DONE) && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			filt_q <= filt_d;
			sat_q  <= ovf;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.filtered  = filt_q;
	assign result.saturated = sat_q;

	// A fresh result beat only ever comes out of the done state.
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside the done state");

	// A shift past warm-up always starts the alignment phase.
	a_shift_starts: assert property (@(posedge clk) disable iff (!arst_n)
		do_result |=> (state_q == ST_SHIFT) && (cnt_q == '0))
		else $error("result-producing shift did not start the sequencer");

	// The alignment counter never runs past the distance the operands must travel.
	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (cnt_q <= shift_amt))
		else $error("operand chain moved too far");

	// The sum phase ends exactly when the chain has settled.
	a_sum_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && $past(state_q == ST_SUM) |-> $past(cnt_q == TAPS_C))
		else $error("sum phase left before the chain settled");

endmodule

`default_nettype wire

// File: sim/centered_fir_convolution_test.sv
`default_nettype none

module centered_fir_convolution_test;

	localparam int TAPS = 64;
	// Wait comfortably longer than the worst filter occupancy before touching the
	// register, as tap writes and clears return no beat.
	localparam int DRAIN_CYCLES = 3 * TAPS + 16;
	localparam logic [cfc_pkg::CFG_ADDR_W-1:0] TAP_COUNT_ADDR =
		{cfc_pkg::REG_TAP_COUNT, 2'b00};
	localparam longint RES_MAX = (longint'(1) <<< (cfc_pkg::RES_W - 1)) - 1;
	localparam longint RES_MIN = -(longint'(1) <<< (cfc_pkg::RES_W - 1));

	// One item as offered on the input channel.
	typedef struct {
		logic [cfc_pkg::FUNC_W-1:0]       func;
		logic [cfc_pkg::TIDX_W-1:0]       tap_index;
		logic signed [cfc_pkg::TAP_W-1:0] tap_value;
		logic signed [cfc_pkg::SMP_W-1:0] sample;
	} fir_item_t;

	// One filter output beat.
	typedef struct {
		logic signed [cfc_pkg::RES_W-1:0] filtered;
		logic                             saturated;
	} fir_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [cfc_pkg::CFG_ADDR_W-1:0] paddr;
	logic [cfc_pkg::CFG_DATA_W-1:0] pwdata;
	logic [cfc_pkg::CFG_DATA_W-1:0] prdata;
	logic                           pready;

	cfc_item_if   in_ch ();
	cfc_result_if out_ch ();

	centered_fir_convolution #(
		.TAPS(TAPS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(in_ch),
		.result(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Items waiting for the driver, and the filter outputs we still expect to
	// see, oldest first.
	fir_item_t   items_to_send[$];
	fir_result_t predicted_results[$];

	// Our own copy of the filter state: coefficients, delay line (newest value
	// at index 0), the warm-up counter and the tap_count register.
	logic signed [cfc_pkg::TAP_W-1:0] coef_copy [TAPS];
	logic signed [cfc_pkg::SMP_W-1:0] delay_copy [TAPS];
	int unsigned                      warm_copy;
	logic [cfc_pkg::TCNT_W-1:0]       tap_count_cfg;

	int unsigned items_queued;
	int unsigned items_taken;
	int unsigned mismatches;

	// Driver and receiver pacing.
	fir_item_t   next_item;
	int unsigned src_gap;
	int unsigned src_calm;
	int unsigned src_roll;
	int unsigned snk_stall;
	int unsigned snk_calm;
	int unsigned snk_roll;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Every mismatch comes through here: one line each, and a running count.
	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	// Pause length in cycles: mostly short, now and then long.
	function automatic int unsigned pause_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end else if (r < 93) begin
			return $urandom_range(4, 9);
		end
		return $urandom_range(20, 80);
	endfunction

	// The kernel length actually in use: the register clamped to [1, TAPS].
	function automatic int unsigned eff_taps();
		if (tap_count_cfg == 0) begin
			return 1;
		end else if (tap_count_cfg > TAPS) begin
			return TAPS;
		end
		return tap_count_cfg;
	endfunction

	// Advance the state copy by one accepted item and queue the output beat it
	// should produce, if any. The kernel is applied as stored (correlation), so
	// tap j meets the sample K-1-j places back in the delay line.
	function automatic void filter_step(input fir_item_t it);
		int unsigned k;
		int unsigned need;
		int unsigned m;
		longint      acc;
		longint      q;
		fir_result_t res;
		case (it.func)
			cfc_pkg::FN_TAP: begin
				// The index field cannot reach beyond TAPS at this size, but keep
				// the rule that such a write would be dropped.
				if (it.tap_index < TAPS) begin
					coef_copy[it.tap_index] = it.tap_value;
				end
			end
			cfc_pkg::FN_CLEAR: begin
				for (m = 0; m < TAPS; m++) begin
					delay_copy[m] = '0;
				end
				warm_copy = 0;
			end
			default: begin
				for (m = TAPS - 1; m > 0; m--) begin
					delay_copy[m] = delay_copy[m - 1];
				end
				delay_copy[0] = (it.func == cfc_pkg::FN_SAMPLE) ? it.sample : '0;
				// The warm-up threshold follows the current kernel length, so a
				// change of tap_count can suppress or release beats mid-stream.
				k = eff_taps();
				need = k - 1 - k / 2;
				if (warm_copy < need) begin
					warm_copy++;
				end else begin
					warm_copy = need;
					acc = 0;
					for (m = 0; m < k; m++) begin
						acc += longint'(coef_copy[m]) * longint'(delay_copy[k - 1 - m]);
					end
					// Arithmetic shift floors towards minus infinity.
					q = acc >>> cfc_pkg::FRAC_BITS;
					res.saturated = 1'b0;
					if (q > RES_MAX) begin
						q = RES_MAX;
						res.saturated = 1'b1;
					end else if (q < RES_MIN) begin
						q = RES_MIN;
						res.saturated = 1'b1;
					end
					res.filtered = cfc_pkg::RES_W'(q);
					predicted_results.push_back(res);
				end
			end
		endcase
	endfunction

	task automatic queue_item(input fir_item_t it);
		items_to_send.push_back(it);
		items_queued++;
	endtask

	// One APB transfer: setup cycle, then access cycle until pready. Read data
	// is sampled at the completing edge.
	task automatic apb_cycle(input logic wr, input logic [cfc_pkg::CFG_DATA_W-1:0] wdata,
			output logic [cfc_pkg::CFG_DATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= TAP_COUNT_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Write tap_count, mirror it in our copy and read it back.
	task automatic set_tap_count(input logic [cfc_pkg::TCNT_W-1:0] k);
		logic [cfc_pkg::CFG_DATA_W-1:0] rd;
		apb_cycle(1'b1, cfc_pkg::CFG_DATA_W'(k), rd);
		tap_count_cfg = k;
		apb_cycle(1'b0, '0, rd);
		if (rd[cfc_pkg::TCNT_W-1:0] !== k) begin
			report_mismatch($sformatf("tap_count reads %0d, wrote %0d",
				rd[cfc_pkg::TCNT_W-1:0], k));
		end
	endtask

	// Hold the sender back until every queued item has been taken and every
	// expected beat has arrived, then let the filter run dry before going on.
	task automatic settle();
		while (items_taken != items_queued || predicted_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random traffic for one register setting. Most items are shifts with random
	// content; tap writes lean towards taps that the current kernel uses, and an
	// occasional clear restarts the warm-up.
	task automatic queue_random(input int unsigned n);
		int unsigned r;
		int unsigned k;
		fir_item_t   it;
		k = eff_taps();
		repeat (n) begin
			r = $urandom_range(0, 99);
			it.tap_index = cfc_pkg::TIDX_W'($urandom());
			it.tap_value = cfc_pkg::TAP_W'($urandom());
			it.sample = cfc_pkg::SMP_W'($urandom());
			if (r < 9) begin
				it.func = cfc_pkg::FN_TAP;
				if ($urandom_range(0, 1) == 0) begin
					it.tap_index = cfc_pkg::TIDX_W'($urandom_range(0, k - 1));
				end
				if ($urandom_range(0, 7) == 0) begin
					case ($urandom_range(0, 3))
						0: it.tap_value = 24'sh7FFFFF;
						1: it.tap_value = 24'sh800000;
						2: it.tap_value = '0;
						default: it.tap_value = '1;
					endcase
				end
			end else if (r < 11) begin
				it.func = cfc_pkg::FN_CLEAR;
			end else if (r < 22) begin
				it.func = cfc_pkg::FN_PAD;
			end else begin
				it.func = cfc_pkg::FN_SAMPLE;
				if ($urandom_range(0, 9) == 0) begin
					it.sample = ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
				end
			end
			queue_item(it);
		end
	endtask

	// Driver: offers one item at a time, holds it until taken, and leaves a
	// random gap after each beat. Every so often a calm stretch sends items
	// back to back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.func <= cfc_pkg::FN_TAP;
			in_ch.tap_index <= '0;
			in_ch.tap_value <= '0;
			in_ch.sample <= '0;
			src_gap = 0;
			src_calm = 0;
		end else if (in_ch.valid && !in_ch.ready) begin
			// The beat is still on offer and must not change.
		end else if (src_gap != 0) begin
			src_gap--;
			in_ch.valid <= 1'b0;
		end else if (items_to_send.size() != 0) begin
			next_item = items_to_send.pop_front();
			in_ch.valid <= 1'b1;
			in_ch.func <= next_item.func;
			in_ch.tap_index <= next_item.tap_index;
			in_ch.tap_value <= next_item.tap_value;
			in_ch.sample <= next_item.sample;
			if (src_calm != 0) begin
				src_calm--;
				src_gap = 0;
			end else begin
				src_roll = $urandom_range(0, 99);
				if (src_roll < 3) begin
					src_calm = $urandom_range(20, 80);
				end
				src_gap = (src_roll < 55) ? 0 : pause_len();
			end
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// Monitor and receiver: feeds each accepted item to the state copy, checks
	// each output beat against the oldest prediction, and stalls ready at random,
	// including long stalls and calm stretches with ready held high.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			snk_stall = 0;
			snk_calm = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (predicted_results.size() == 0) begin
					report_mismatch($sformatf("beat with nothing expected: filtered %0d",
						out_ch.filtered));
				end else begin
					if (out_ch.filtered !== predicted_results[0].filtered) begin
						report_mismatch($sformatf("filtered is %0d, expected %0d",
							out_ch.filtered, predicted_results[0].filtered));
					end
					if (out_ch.saturated !== predicted_results[0].saturated) begin
						report_mismatch($sformatf("saturated is %b, expected %b",
							out_ch.saturated, predicted_results[0].saturated));
					end
					void'(predicted_results.pop_front());
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				items_taken++;
				filter_step('{in_ch.func, in_ch.tap_index, in_ch.tap_value, in_ch.sample});
			end
			if (snk_stall != 0) begin
				snk_stall--;
				out_ch.ready <= 1'b0;
			end else if (snk_calm != 0) begin
				snk_calm--;
				out_ch.ready <= 1'b1;
			end else begin
				snk_roll = $urandom_range(0, 99);
				if (snk_roll < 12) begin
					snk_stall = pause_len() - 1;
					out_ch.ready <= 1'b0;
				end else begin
					if (snk_roll == 99) begin
						snk_calm = $urandom_range(300, 1500);
					end
					out_ch.ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		logic [cfc_pkg::TCNT_W-1:0]     settings [12];
		logic [cfc_pkg::CFG_DATA_W-1:0] rd;
		int                             m;

		// Known values on every input from the very start.
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.func = cfc_pkg::FN_TAP;
		in_ch.tap_index = '0;
		in_ch.tap_value = '0;
		in_ch.sample = '0;
		out_ch.ready = 1'b0;
		for (m = 0; m < TAPS; m++) begin
			coef_copy[m] = '0;
			delay_copy[m] = '0;
		end
		warm_copy = 0;
		tap_count_cfg = cfc_pkg::TAP_COUNT_RESET;
		items_queued = 0;
		items_taken = 0;
		mismatches = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// The register must come out of reset at its documented value.
		apb_cycle(1'b0, '0, rd);
		if (rd[cfc_pkg::TCNT_W-1:0] !== cfc_pkg::TAP_COUNT_RESET) begin
			report_mismatch($sformatf("tap_count resets to %0d", rd[cfc_pkg::TCNT_W-1:0]));
		end

		// Directed part. With the full kernel in place: coefficient extremes and
		// alternating bit patterns at both ends of the store, one warm-up shift
		// and a clear, none of which may return a beat.
		queue_item('{cfc_pkg::FN_TAP, 6'd0, 24'sh7FFFFF, 16'sd0});
		queue_item('{cfc_pkg::FN_TAP, 6'd1, 24'sh800000, 16'sd0});
		queue_item('{cfc_pkg::FN_TAP, 6'd63, 24'sh555555, 16'sd0});
		queue_item('{cfc_pkg::FN_TAP, 6'd2, 24'shAAAAAA, 16'sd0});
		queue_item('{cfc_pkg::FN_TAP, 6'd62, -24'sd1, 16'sd0});
		queue_item('{cfc_pkg::FN_SAMPLE, 6'd0, 24'sd0, 16'sh7FFF});
		queue_item('{cfc_pkg::FN_CLEAR, 6'd0, 24'sd0, 16'sd0});
		settle();

		// A two-tap kernel has no warm-up, so every shift returns a beat: sample
		// extremes, a pad, a coefficient rewritten mid-stream and a clear.
		set_tap_count(7'd2);
		queue_item('{cfc_pkg::FN_SAMPLE, 6'd0, 24'sd0, 16'sh7FFF});
		queue_item('{cfc_pkg::FN_SAMPLE, 6'd0, 24'sd0, 16'sh8000});
		queue_item('{cfc_pkg::FN_PAD, 6'd0, 24'sd0, 16'sh1234});
		queue_item('{cfc_pkg::FN_SAMPLE, 6'd0, 24'sd0, -16'sd1});
		queue_item('{cfc_pkg::FN_SAMPLE, 6'd0, 24'sd0, 16'sd1});
		queue_item('{cfc_pkg::FN_TAP, 6'd1, 24'sd1, 16'sd0});
		queue_item('{cfc_pkg::FN_SAMPLE, 6'd0, 24'sd0, 16'sh5555});
		queue_item('{cfc_pkg::FN_SAMPLE, 6'd0, 24'sd0, 16'shAAAA});
		queue_item('{cfc_pkg::FN_CLEAR, 6'd0, 24'sd0, 16'sd0});
		queue_item('{cfc_pkg::FN_PAD, 6'd0, 24'sd0, 16'sd0});
		queue_item('{cfc_pkg::FN_SAMPLE, 6'd0, 24'sd0, 16'sd0});
		queue_item('{cfc_pkg::FN_TAP, 6'd0, 24'sd0, 16'sd0});
		queue_item('{cfc_pkg::FN_SAMPLE, 6'd0, 24'sd0, 16'sh8000});
		settle();

		// Random part, one phase per register setting. The delay line and the
		// warm-up counter carry over between phases, so raising the tap count
		// suppresses beats again and lowering it releases them at once. Zero and
		// values above TAPS check the clamping.
		settings = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd63, 7'd65,
			7'd31, 7'd2, 7'd100, 7'd64, 7'd3, 7'd48};
		foreach (settings[i]) begin
			set_tap_count(settings[i]);
			queue_random(100);
			settle();
		end

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
sv/cfc_pkg.sv
sv/cfc_stream_if.sv
sv/cfc_cell.sv
sv/cfc_regs.sv
sv/centered_fir_convolution.sv
sim/centered_fir_convolution_test.sv
